// File: design/dkxs_pkg.sv
// Shared types and constants for the dual key index exchange sort.
package dkxs_pkg;

  localparam int READING_W = 9;
  localparam int RANK_W    = 4;

  typedef logic signed [READING_W-1:0] reading_t;

  // Per-lane strobes from the sequencer
  typedef struct packed {
    logic load_we;   // write incoming reading into the value store
    logic perm_rd;   // read permutation entry at the position address
    logic store_rd;  // read value store at the fetched record index
    logic take_cur;  // load the fetched record as the current pivot
    logic swap_we;   // exchange: write pivot into position, adopt fetched record
    logic put_cur;   // write pivot back to its outer position
    logic clear;     // return permutation to identity
  } lane_ctl_t;

endpackage

// File: design/dual_key_index_exchange_sort_core.sv
// Top level: record loader, exchange sort sequencer and result register.
// Records load one per cycle while in_ready is high; a record that finds ENTRIES records
// already stored is dropped and sets the overflowed flag for the run. The transfer marked
// final closes the run and starts the sort, during which in_ready stays low. Both index
// permutations sort together with one shared sequencer over two lanes, each lane holding a
// value RAM and a permutation RAM with registered reads. Every compare step walks
// permutation read, value read and compare/exchange; each outer pass first fetches its
// pivot by permutation read, value read and take, and writes it back at the end. Each
// rank is then read by permutation read and value read before it enters the output
// register, waiting while out_ready holds the previous result. Ranks come out 0 to
// n-1 with end_of_run on the last; after it the permutations return to identity through
// per-entry valid bits, and loading of the next run resumes while the last result may still
// wait in the output register. Rank and index fields carry the low four bits.
module dual_key_index_exchange_sort_core #(
  parameter int ENTRIES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  dkxs_pkg::reading_t in_high_reading,
  input  dkxs_pkg::reading_t in_low_reading,
  input  logic               in_is_final,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [3:0]         out_rank,
  output logic [3:0]         out_high_order_index,
  output dkxs_pkg::reading_t out_high_order_value,
  output logic [3:0]         out_low_order_index,
  output dkxs_pkg::reading_t out_low_order_value,
  output logic               out_overflowed,
  output logic               out_end_of_run
);
  import dkxs_pkg::*;

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);

  localparam logic [3:0] S_LOAD = 4'd0;  // accept records
  localparam logic [3:0] S_IP   = 4'd1;  // pivot: read permutation at i
  localparam logic [3:0] S_IS   = 4'd2;  // pivot: read value
  localparam logic [3:0] S_IT   = 4'd3;  // pivot: take into registers
  localparam logic [3:0] S_JP   = 4'd4;  // candidate: read permutation at j
  localparam logic [3:0] S_JS   = 4'd5;  // candidate: read value
  localparam logic [3:0] S_JC   = 4'd6;  // compare and exchange
  localparam logic [3:0] S_WI   = 4'd7;  // write pivot back to i
  localparam logic [3:0] S_OP   = 4'd8;  // result: read permutation at rank
  localparam logic [3:0] S_OS   = 4'd9;  // result: read value
  localparam logic [3:0] S_OW   = 4'd10; // result: load output register

  logic [3:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          ovf_r, ovf_nxt;
  logic [IW-1:0] i_r, i_nxt;
  logic [IW-1:0] j_r, j_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [3:0]    rank_r, hi_idx_r, lo_idx_r;
  reading_t      hi_val_r, lo_val_r;
  logic          ovf_out_r, end_r;

  lane_ctl_t     hi_ctl, lo_ctl, base_ctl;
  logic [IW-1:0] pos_addr;
  logic [IW-1:0] hi_idx, lo_idx;
  reading_t      hi_rec, lo_rec, hi_cur, lo_cur;
  logic          in_xfer, out_free, cap, room, last_rank;
  logic          swap_hi, swap_lo;

  assign in_ready  = (state_r == S_LOAD);
  assign in_xfer   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign room      = cnt_r < CW'(ENTRIES);
  assign last_rank = (CW'(i_r) + CW'(1)) == cnt_r;
  assign cap       = (state_r == S_OW) && out_free;

  // Descending by high reading, ascending by low reading; strict compares never exchange equal readings
  assign swap_hi = hi_cur < hi_rec;
  assign swap_lo = lo_cur > lo_rec;

  always_comb begin
    case (state_r)
      S_JP:    pos_addr = j_r;
      default: pos_addr = i_r;
    endcase
  end

  always_comb begin
    base_ctl          = '0;
    base_ctl.load_we  = in_xfer && room;
    base_ctl.perm_rd  = (state_r == S_IP) || (state_r == S_JP) || (state_r == S_OP);
    base_ctl.store_rd = (state_r == S_IS) || (state_r == S_JS) || (state_r == S_OS);
    base_ctl.take_cur = (state_r == S_IT);
    base_ctl.put_cur  = (state_r == S_WI);
    base_ctl.clear    = cap && last_rank;
    hi_ctl            = base_ctl;
    lo_ctl            = base_ctl;
    hi_ctl.swap_we    = (state_r == S_JC) && swap_hi;
    lo_ctl.swap_we    = (state_r == S_JC) && swap_lo;
  end

  dkxs_lane #(.ENTRIES(ENTRIES)) u_hi_lane (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (hi_ctl),
    .load_addr (cnt_r[IW-1:0]),
    .load_val  (in_high_reading),
    .pos_addr  (pos_addr),
    .put_addr  (i_r),
    .rec_idx   (hi_idx),
    .rec_val   (hi_rec),
    .cur_val   (hi_cur)
  );

  dkxs_lane #(.ENTRIES(ENTRIES)) u_lo_lane (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (lo_ctl),
    .load_addr (cnt_r[IW-1:0]),
    .load_val  (in_low_reading),
    .pos_addr  (pos_addr),
    .put_addr  (i_r),
    .rec_idx   (lo_idx),
    .rec_val   (lo_rec),
    .cur_val   (lo_cur)
  );

  // Sequencer: load, nested exchange passes, rank readout
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ovf_nxt       = ovf_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_LOAD: begin
        if (in_xfer) begin
          if (room) begin
            cnt_nxt = cnt_r + CW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_is_final) begin
            i_nxt = '0;
            j_nxt = IW'(1);
            // A single record needs no sorting
            state_nxt = (cnt_nxt >= CW'(2)) ? S_IP : S_OP;
          end
        end
      end
      S_IP: state_nxt = S_IS;
      S_IS: state_nxt = S_IT;
      S_IT: state_nxt = S_JP;
      S_JP: state_nxt = S_JS;
      S_JS: state_nxt = S_JC;
      S_JC: begin
        if ((CW'(j_r) + CW'(1)) == cnt_r) begin
          state_nxt = S_WI;
        end else begin
          j_nxt     = j_r + IW'(1);
          state_nxt = S_JP;
        end
      end
      S_WI: begin
        if ((CW'(i_r) + CW'(2)) < cnt_r) begin
          i_nxt     = i_r + IW'(1);
          j_nxt     = i_r + IW'(2);
          state_nxt = S_IP;
        end else begin
          i_nxt     = '0;
          state_nxt = S_OP;
        end
      end
      S_OP: state_nxt = S_OS;
      S_OS: state_nxt = S_OW;
      S_OW: begin
        // Hold until the output register frees up
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (last_rank) begin
            cnt_nxt   = '0;
            ovf_nxt   = 1'b0;
            state_nxt = S_LOAD;
          end else begin
            i_nxt     = i_r + IW'(1);
            state_nxt = S_OP;
          end
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r <= i_nxt;
    j_r <= j_nxt;
    if (cap) begin
      rank_r    <= 4'(i_r);
      hi_idx_r  <= 4'(hi_idx);
      hi_val_r  <= hi_rec;
      lo_idx_r  <= 4'(lo_idx);
      lo_val_r  <= lo_rec;
      ovf_out_r <= ovf_r;
      end_r     <= last_rank;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_rank             = rank_r;
  assign out_high_order_index = hi_idx_r;
  assign out_high_order_value = hi_val_r;
  assign out_low_order_index  = lo_idx_r;
  assign out_low_order_value  = lo_val_r;
  assign out_overflowed       = ovf_out_r;
  assign out_end_of_run       = end_r;

endmodule

// File: design/dkxs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dkxs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: design/dkxs_lane.sv
// One sort lane: value store, index permutation with identity override, pivot registers.
module dkxs_lane #(
  parameter int ENTRIES = 16,
  localparam int IW = $clog2(ENTRIES)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  dkxs_pkg::lane_ctl_t ctl,
  input  logic [IW-1:0]     load_addr,
  input  dkxs_pkg::reading_t load_val,
  input  logic [IW-1:0]     pos_addr,
  input  logic [IW-1:0]     put_addr,
  output logic [IW-1:0]     rec_idx,
  output dkxs_pkg::reading_t rec_val,
  output dkxs_pkg::reading_t cur_val
);
  import dkxs_pkg::*;

  logic [IW-1:0]        perm_rdata;
  logic [IW-1:0]        perm_q;
  logic [IW-1:0]        perm_waddr;
  logic                 perm_we;
  logic [READING_W-1:0] store_rdata;
  logic [IW-1:0]        pos_r;
  logic [IW-1:0]        idx_r;
  logic [IW-1:0]        cur_idx_r;
  reading_t             cur_val_r;
  logic [ENTRIES-1:0]   valid_r;

  // An entry never written since the last clear holds its own index
  assign perm_q     = valid_r[pos_r] ? perm_rdata : pos_r;
  assign perm_we    = ctl.swap_we | ctl.put_cur;
  assign perm_waddr = ctl.put_cur ? put_addr : pos_r;

  dkxs_ram #(.WIDTH(IW), .DEPTH(ENTRIES)) u_perm (
    .clk   (clk),
    .we    (perm_we),
    .waddr (perm_waddr),
    .wdata (cur_idx_r),
    .re    (ctl.perm_rd),
    .raddr (pos_addr),
    .rdata (perm_rdata)
  );

  dkxs_ram #(.WIDTH(READING_W), .DEPTH(ENTRIES)) u_store (
    .clk   (clk),
    .we    (ctl.load_we),
    .waddr (load_addr),
    .wdata (load_val),
    .re    (ctl.store_rd),
    .raddr (perm_q),
    .rdata (store_rdata)
  );

  assign rec_idx = idx_r;
  assign rec_val = signed'(store_rdata);
  assign cur_val = cur_val_r;

  always_ff @(posedge clk) begin
    if (ctl.perm_rd) begin
      pos_r <= pos_addr;
    end
    if (ctl.store_rd) begin
      idx_r <= perm_q;
    end
    if (ctl.take_cur || ctl.swap_we) begin
      cur_idx_r <= idx_r;
      cur_val_r <= rec_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      valid_r <= '0;
    end else if (perm_we) begin
      valid_r[perm_waddr] <= 1'b1;
    end
  end

endmodule

// File: design/dkxs_checker.sv
// Port-level checker for the exchange sort core, bound to the top level.
module dkxs_checker #(
  parameter int ENTRIES = 16
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               in_is_final,
  input logic               out_valid,
  input logic               out_ready,
  input logic [3:0]         out_rank,
  input logic [3:0]         out_high_order_index,
  input dkxs_pkg::reading_t out_high_order_value,
  input logic [3:0]         out_low_order_index,
  input dkxs_pkg::reading_t out_low_order_value,
  input logic               out_end_of_run
);

  logic [3:0] exp_rank_r;
  logic       out_xfer;

  assign out_xfer = out_valid && out_ready;

  // Track the rank the next result must carry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_rank_r <= '0;
    end else if (out_xfer) begin
      exp_rank_r <= out_end_of_run ? 4'd0 : exp_rank_r + 4'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_rank)
      && $stable(out_high_order_index) && $stable(out_low_order_index)
      && $stable(out_high_order_value) && $stable(out_low_order_value))
    else $error("result changed while stalled");

  a_rank_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_rank == exp_rank_r)
    else $error("rank out of sequence");

  a_final_closes: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_is_final |=> !in_ready)
    else $error("input taken during sort");

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (ENTRIES > 16) || ({1'b0, out_high_order_index} < 5'(ENTRIES)
      && {1'b0, out_low_order_index} < 5'(ENTRIES)))
    else $error("record index beyond capacity");

endmodule

bind dual_key_index_exchange_sort_core dkxs_checker #(.ENTRIES(ENTRIES)) u_dkxs_checker (.*);
